>>> hw/rtl/in_place_matrix_transpose_assert.svh
// Assertion macros for the in-place matrix transpose block.
// Used by hw/rtl/in_place_matrix_transpose.sv; expects clk and rst_n in scope.
`ifndef IN_PLACE_MATRIX_TRANSPOSE_ASSERT_SVH
`define IN_PLACE_MATRIX_TRANSPOSE_ASSERT_SVH
`ifndef SYNTHESIS
`define IPMT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipmt assertion failed");
`define IPMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipmt assertion failed");
`else
`define IPMT_ASSERT(lbl, ante, cons)
`define IPMT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/ipmt_pkg.sv
// Shared types and codes for the in-place matrix transpose block.
// No dependencies; used by the channel interfaces and the top level.
package ipmt_pkg;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 12;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int DIM_W     = 7;
  localparam int PROD_W    = 2 * DIM_W;
  localparam int CFG_IDX_W = 8;

  typedef logic [OP_W-1:0]      op_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_RUN   = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  localparam kind_t KIND_READ    = 2'd0;
  localparam kind_t KIND_DONE    = 2'd1;
  localparam kind_t KIND_REFUSED = 2'd2;

  localparam cfg_idx_t REG_ROW_COUNT    = 8'd0;
  localparam cfg_idx_t REG_COLUMN_COUNT = 8'd1;

endpackage

>>> hw/rtl/ipmt_if.sv
// Valid/ready channel interfaces for the in-place matrix transpose block.
// Depends on ipmt_pkg.
interface ipmt_in_if;
  import ipmt_pkg::*;
  logic  valid;
  logic  ready;
  op_t   operation;
  idx_t  cell_index;
  data_t element_value;
  modport source (output valid, operation, cell_index, element_value, input ready);
  modport sink   (input valid, operation, cell_index, element_value, output ready);
endinterface

interface ipmt_out_if;
  import ipmt_pkg::*;
  logic  valid;
  logic  ready;
  kind_t result_kind;
  data_t read_value;
  modport source (output valid, result_kind, read_value, input ready);
  modport sink   (input valid, result_kind, read_value, output ready);
endinterface

interface ipmt_cfg_if;
  import ipmt_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t reg_index;
  dim_t     reg_data;
  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

>>> hw/rtl/in_place_matrix_transpose.sv
// Write: stored as the item is taken. Read: store read, result then held in the output register.
// Transpose: a size check (a refusal is answered then), first-column elements gathered to
// the front by swaps, a setup per later column, later elements swapped in directly if free;
// a displaced one is found by following the permutation cycle (a bitwise divide and a
// multiply-add per step), then swapped if found; then answered; no item taken meanwhile.
// Reset clears control state, sets row_count and column_count to 1; store not cleared.
module in_place_matrix_transpose #(
  parameter int MAX_CELLS     = 4096,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  ipmt_in_if.sink      in_ch,
  ipmt_out_if.source   out_ch,
  ipmt_cfg_if.sink     cfg_ch
);
  import ipmt_pkg::*;

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int PW = $clog2(MAX_CELLS + 1);
  localparam int CW = (PW > 1) ? $clog2(PW) : 1;
  localparam int EW = ELEMENT_WIDTH;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_READ    = 5'd1;
  localparam logic [4:0] S_SIZE    = 5'd2;
  localparam logic [4:0] S_CHK     = 5'd3;
  localparam logic [4:0] S_G_MUL   = 5'd4;
  localparam logic [4:0] S_G_NEXT  = 5'd5;
  localparam logic [4:0] S_C_START = 5'd6;
  localparam logic [4:0] S_SRC     = 5'd7;
  localparam logic [4:0] S_FREE0   = 5'd8;
  localparam logic [4:0] S_SEARCH  = 5'd9;
  localparam logic [4:0] S_DIV     = 5'd10;
  localparam logic [4:0] S_PERM    = 5'd11;
  localparam logic [4:0] S_CHKP    = 5'd12;
  localparam logic [4:0] S_R_NEXT  = 5'd13;
  localparam logic [4:0] S_DONE    = 5'd14;
  localparam logic [4:0] S_SW_RA   = 5'd15;
  localparam logic [4:0] S_SW_RB   = 5'd16;
  localparam logic [4:0] S_SW_WA   = 5'd17;
  localparam logic [4:0] S_SW_WB   = 5'd18;

  function automatic logic is_free(input logic [PW-1:0] s, input logic [PW-1:0] lo,
                                   input logic [PW-1:0] tgt, input logic [PW-1:0] hi);
    is_free = ((s > lo) && (s <= tgt)) || (s > hi);
  endfunction

  logic [EW-1:0] mem [MAX_CELLS];
  logic [EW-1:0] rdata_r;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_we;

  logic [4:0]    state_r, state_nxt;
  logic [4:0]    ret_r, ret_nxt;
  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r, out_kind_nxt;
  data_t         out_value_r, out_value_nxt;
  dim_t          rows_r, rows_nxt;
  dim_t          cols_r, cols_nxt;
  logic [PW-1:0] target_r, target_nxt;
  logic [PW-1:0] lock_low_r, lock_low_nxt;
  logic [PW-1:0] lock_high_r, lock_high_nxt;
  logic [PW-1:0] cells_r, cells_nxt;
  logic [PW-1:0] steps_r, steps_nxt;
  logic [PW-1:0] prev_r, prev_nxt;
  logic [PW-1:0] q_r, q_nxt;
  dim_t          rem_r, rem_nxt;
  logic [CW-1:0] div_cnt_r, div_cnt_nxt;
  dim_t          r_r, r_nxt;
  dim_t          c_r, c_nxt;
  logic [AW-1:0] sw_a_r, sw_a_nxt;
  logic [AW-1:0] sw_b_r, sw_b_nxt;
  logic [EW-1:0] hold_r, hold_nxt;
  logic [PROD_W-1:0] size_r, size_nxt;
  logic          oob_r, oob_nxt;

  dim_t              mul_a;
  dim_t              mul_c;
  logic [PROD_W-1:0] mul_prod;
  logic [PROD_W-1:0] mul_sum;
  logic [DIM_W:0]    rem_sh;
  logic [DIM_W:0]    rem_diff;
  logic              rem_ge;
  logic [63:0]       wr_ext;
  logic [63:0]       rd_ext;
  logic              in_fire;
  logic              out_fire;
  logic              cfg_fire;
  logic              idx_ok;
  logic [PW-1:0]     col_end;

  assign in_ch.ready   = rst_n && (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_fire      = out_valid_r && out_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.read_value  = out_value_r;
  assign cfg_ch.ready  = rst_n && (state_r == S_IDLE);
  assign cfg_fire      = cfg_ch.valid && cfg_ch.ready;

  assign idx_ok  = (32'(in_ch.cell_index) < 32'(MAX_CELLS));
  assign wr_ext  = {32'd0, in_ch.element_value};
  assign rd_ext  = 64'(rdata_r);
  assign col_end = target_r + PW'(rows_r) - PW'(1);

  // shared multiply-add: a * cols + c
  always_comb begin
    case (state_r)
      S_SIZE:  begin mul_a = rows_r;         mul_c = '0;        end
      S_G_MUL: begin mul_a = r_r;            mul_c = '0;        end
      S_SRC:   begin mul_a = r_r - 7'd1;     mul_c = c_r;       end
      S_PERM:  begin mul_a = rem_r;          mul_c = DIM_W'(q_r); end
      default: begin mul_a = rows_r;         mul_c = '0;        end
    endcase
  end
  assign mul_prod = mul_a * cols_r;
  assign mul_sum  = mul_prod + PROD_W'(mul_c);

  // one quotient bit per cycle
  assign rem_sh   = {rem_r, q_r[PW-1]};
  assign rem_ge   = rem_sh >= {1'b0, rows_r};
  assign rem_diff = rem_sh - {1'b0, rows_r};

  always_comb begin
    mem_raddr = sw_a_r;
    mem_waddr = sw_a_r;
    mem_wdata = rdata_r;
    mem_we    = 1'b0;
    case (state_r)
      S_IDLE: begin
        mem_raddr = AW'(in_ch.cell_index);
        mem_waddr = AW'(in_ch.cell_index);
        mem_wdata = wr_ext[EW-1:0];
        mem_we    = in_fire && (in_ch.operation == OP_WRITE) && idx_ok;
      end
      S_SW_RB: mem_raddr = sw_b_r;
      S_SW_WA: mem_we = 1'b1;
      S_SW_WB: begin
        mem_waddr = sw_b_r;
        mem_wdata = hold_r;
        mem_we    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    out_valid_nxt = out_valid_r && !out_fire;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    target_nxt    = target_r;
    lock_low_nxt  = lock_low_r;
    lock_high_nxt = lock_high_r;
    cells_nxt     = cells_r;
    steps_nxt     = steps_r;
    prev_nxt      = prev_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    sw_a_nxt      = sw_a_r;
    sw_b_nxt      = sw_b_r;
    hold_nxt      = hold_r;
    size_nxt      = size_r;
    oob_nxt       = oob_r;

    if (cfg_fire) begin
      if (cfg_ch.reg_index == REG_ROW_COUNT) begin
        rows_nxt = cfg_ch.reg_data;
      end else if (cfg_ch.reg_index == REG_COLUMN_COUNT) begin
        cols_nxt = cfg_ch.reg_data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.operation == OP_READ) begin
            oob_nxt   = !idx_ok;
            state_nxt = S_READ;
          end else if (in_ch.operation == OP_RUN) begin
            state_nxt = S_SIZE;
          end
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_READ;
        out_value_nxt = oob_r ? '0 : rd_ext[DATA_W-1:0];
        state_nxt     = S_IDLE;
      end
      S_SIZE: begin
        size_nxt  = mul_sum;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if ((size_r == '0) || (32'(size_r) > 32'(MAX_CELLS))) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_REFUSED;
          out_value_nxt = '0;
          state_nxt     = S_IDLE;
        end else begin
          cells_nxt     = PW'(size_r);
          target_nxt    = '0;
          lock_low_nxt  = '0;
          lock_high_nxt = '0;
          r_nxt         = '0;
          state_nxt     = S_G_MUL;
        end
      end
      // gather the first column to the front
      S_G_MUL: begin
        sw_a_nxt  = AW'(target_r);
        sw_b_nxt  = AW'(mul_sum);
        ret_nxt   = S_G_NEXT;
        state_nxt = S_SW_RA;
      end
      S_G_NEXT: begin
        target_nxt = target_r + PW'(1);
        r_nxt      = r_r + 7'd1;
        if ((r_r + 7'd1) == rows_r) begin
          lock_low_nxt = target_r;
          c_nxt        = 7'd1;
          state_nxt    = (cols_r == 7'd1) ? S_DONE : S_C_START;
        end else begin
          state_nxt = S_G_MUL;
        end
      end
      S_C_START: begin
        target_nxt    = col_end;
        lock_high_nxt = col_end;
        r_nxt         = rows_r;
        state_nxt     = S_SRC;
      end
      S_SRC: begin
        prev_nxt  = PW'(mul_sum);
        state_nxt = S_FREE0;
      end
      S_FREE0: begin
        if (is_free(prev_r, lock_low_r, target_r, lock_high_r)) begin
          sw_a_nxt  = AW'(target_r);
          sw_b_nxt  = AW'(prev_r);
          ret_nxt   = S_R_NEXT;
          state_nxt = S_SW_RA;
        end else begin
          steps_nxt = '0;
          state_nxt = S_SEARCH;
        end
      end
      // follow the permutation cycle back
      S_SEARCH: begin
        if (steps_r < cells_r) begin
          q_nxt       = prev_r;
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end else begin
          state_nxt = S_R_NEXT;
        end
      end
      S_DIV: begin
        rem_nxt     = rem_ge ? rem_diff[DIM_W-1:0] : rem_sh[DIM_W-1:0];
        q_nxt       = {q_r[PW-2:0], rem_ge};
        div_cnt_nxt = div_cnt_r + CW'(1);
        if (div_cnt_r == CW'(PW - 1)) begin
          state_nxt = S_PERM;
        end
      end
      S_PERM: begin
        prev_nxt  = PW'(mul_sum);
        state_nxt = S_CHKP;
      end
      S_CHKP: begin
        steps_nxt = steps_r + PW'(1);
        if (is_free(prev_r, lock_low_r, target_r, lock_high_r)) begin
          sw_a_nxt  = AW'(target_r);
          sw_b_nxt  = AW'(prev_r);
          ret_nxt   = S_R_NEXT;
          state_nxt = S_SW_RA;
        end else if (prev_r == target_r) begin
          state_nxt = S_R_NEXT;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_R_NEXT: begin
        target_nxt = target_r - PW'(1);
        r_nxt      = r_r - 7'd1;
        if (r_r == 7'd1) begin
          target_nxt   = lock_high_r + PW'(1);
          lock_low_nxt = lock_high_r;
          c_nxt        = c_r + 7'd1;
          state_nxt    = ((c_r + 7'd1) == cols_r) ? S_DONE : S_C_START;
        end else begin
          state_nxt = S_SRC;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_DONE;
        out_value_nxt = '0;
        state_nxt     = S_IDLE;
      end
      // element exchange over the store's single read port and single write port
      S_SW_RA: state_nxt = S_SW_RB;
      S_SW_RB: begin
        hold_nxt  = rdata_r;
        state_nxt = S_SW_WA;
      end
      S_SW_WA: state_nxt = S_SW_WB;
      S_SW_WB: state_nxt = ret_r;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rows_r      <= 7'd1;
      cols_r      <= 7'd1;
      target_r    <= '0;
      lock_low_r  <= '0;
      lock_high_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      target_r    <= target_nxt;
      lock_low_r  <= lock_low_nxt;
      lock_high_r <= lock_high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r       <= ret_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    cells_r     <= cells_nxt;
    steps_r     <= steps_nxt;
    prev_r      <= prev_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    r_r         <= r_nxt;
    c_r         <= c_nxt;
    sw_a_r      <= sw_a_nxt;
    sw_b_r      <= sw_b_nxt;
    hold_r      <= hold_nxt;
    size_r      <= size_nxt;
    oob_r       <= oob_nxt;
  end

`include "in_place_matrix_transpose_assert.svh"

  `IPMT_ASSERT(a_swap_a_in_matrix, state_r == S_SW_WA, 32'(sw_a_r) < 32'(cells_r))
  `IPMT_ASSERT(a_swap_b_in_matrix, state_r == S_SW_WB, 32'(sw_b_r) < 32'(cells_r))
  `IPMT_ASSERT(a_rem_below_rows, state_r == S_PERM, rem_r < rows_r)
  `IPMT_ASSERT_NEXT(a_perm_in_matrix, state_r == S_PERM, 32'(prev_r) < 32'(cells_r))
  `IPMT_ASSERT(a_done_slot_free, (state_r == S_DONE) || (state_r == S_READ), !out_valid_r)

endmodule

>>> tb/sv/tb_in_place_matrix_transpose.sv
// Testbench for in_place_matrix_transpose: element writes and reads, transposes
// over many shapes, checked item by item against a shadow store in a scoreboard.
// Depends on ipmt_pkg and the channel interfaces in ipmt_if.sv.
module tb_in_place_matrix_transpose;
  import ipmt_pkg::*;

  localparam int unsigned CELL_CAPACITY = 4096;
  localparam int unsigned ITEM_TARGET   = 1950;
  localparam int unsigned CALM_FROM     = 1650;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned MAX_PRINTED   = 50;

  localparam op_t      OP_UNUSED  = 2'd3;
  localparam cfg_idx_t REG_UNUSED = 8'hFF;

  class transpose_checker;
    data_t       shadow_cells [CELL_CAPACITY];
    bit          shadow_known [CELL_CAPACITY];
    dim_t        row_reg;
    dim_t        col_reg;
    int unsigned fill_pos;
    int unsigned fixed_low;
    int unsigned fixed_high;
    kind_t       due_kind [$];
    data_t       due_value [$];
    int unsigned errors;
    int unsigned read_count;
    int unsigned done_count;
    int unsigned refused_count;
    int unsigned work_bound;

    function new();
      row_reg       = 1;
      col_reg       = 1;
      fill_pos      = 0;
      fixed_low     = 0;
      fixed_high    = 0;
      errors        = 0;
      read_count    = 0;
      done_count    = 0;
      refused_count = 0;
      work_bound    = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function int due_count();
      return due_kind.size();
    endfunction

    function bit slot_free(int unsigned s);
      return (s > fixed_low && s <= fill_pos) || s > fixed_high;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      data_t v;
      bit    k;
      if (a >= CELL_CAPACITY || b >= CELL_CAPACITY) return;
      v               = shadow_cells[a];
      shadow_cells[a] = shadow_cells[b];
      shadow_cells[b] = v;
      k               = shadow_known[a];
      shadow_known[a] = shadow_known[b];
      shadow_known[b] = k;
    endfunction

    // column 0 is gathered first, later columns placed back to front,
    // displaced sources found by walking the permutation cycle
    function void shadow_transpose(int unsigned rows, int unsigned cols, int unsigned cells);
      int unsigned r;
      int unsigned c;
      int unsigned src;
      int unsigned prev;
      int unsigned steps;
      int unsigned hops;
      bit          searching;
      hops       = 0;
      fill_pos   = 0;
      fixed_low  = 0;
      fixed_high = 0;
      for (r = 0; r < rows; r++) begin
        swap_slots(fill_pos, r * cols);
        fill_pos++;
      end
      fixed_low = fill_pos - 1;
      for (c = 1; c < cols; c++) begin
        fill_pos += rows - 1;
        fixed_high = fill_pos;
        for (r = rows; r > 0; r--) begin
          src = (r - 1) * cols + c;
          if (slot_free(src)) begin
            swap_slots(fill_pos, src);
          end else begin
            prev      = src;
            steps     = 0;
            searching = 1'b1;
            while (searching && steps < cells) begin
              prev = (prev % rows) * cols + prev / rows;
              if (slot_free(prev)) begin
                swap_slots(fill_pos, prev);
                searching = 1'b0;
              end else if (prev == fill_pos) begin
                searching = 1'b0;
              end
              steps++;
            end
            hops += steps;
          end
          fill_pos--;
        end
        fill_pos  = (c + 1) * rows;
        fixed_low = fixed_high;
      end
      work_bound = 4 * (cells * 12 + hops * 24);
    endfunction

    function void take_config(cfg_idx_t idx, dim_t data);
      if (idx == REG_ROW_COUNT) row_reg = data;
      else if (idx == REG_COLUMN_COUNT) col_reg = data;
    endfunction

    function void take_item(op_t op, idx_t idx, data_t val);
      int unsigned rows;
      int unsigned cols;
      int unsigned cells;
      rows  = row_reg;
      cols  = col_reg;
      cells = rows * cols;
      case (op)
        OP_WRITE: begin
          shadow_cells[idx] = val;
          shadow_known[idx] = 1'b1;
        end
        OP_READ: begin
          due_kind.push_back(KIND_READ);
          due_value.push_back(shadow_cells[idx]);
        end
        OP_RUN: begin
          if (cells == 0 || cells > CELL_CAPACITY) begin
            due_kind.push_back(KIND_REFUSED);
          end else begin
            shadow_transpose(rows, cols, cells);
            due_kind.push_back(KIND_DONE);
          end
          due_value.push_back('0);
        end
        default: ;
      endcase
    endfunction

    task check_result(kind_t kind, data_t value);
      kind_t k;
      data_t v;
      if (due_kind.size() == 0) begin
        report($sformatf("unexpected result kind %0d value %h", kind, value));
        return;
      end
      k = due_kind.pop_front();
      v = due_value.pop_front();
      if (kind !== k) report($sformatf("result_kind %0d, predicted %0d", kind, k));
      if (value !== v) report($sformatf("read_value %h, predicted %h (kind %0d)", value, v, k));
      if (k == KIND_READ) read_count++;
      else if (k == KIND_DONE) done_count++;
      else refused_count++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  ipmt_in_if  in_ch ();
  ipmt_out_if out_ch ();
  ipmt_cfg_if cfg_ch ();

  in_place_matrix_transpose #(
    .MAX_CELLS     (CELL_CAPACITY),
    .ELEMENT_WIDTH (DATA_W)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  transpose_checker sb = new();

  int unsigned items_sent = 0;
  int unsigned shapes     = 0;
  bit          calm       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : result_stall
    int unsigned hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.result_kind, out_ch.read_value);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT + sb.work_bound) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no handshake for %0d cycles, %0d results outstanding",
             quiet, sb.due_count());
    $display("[in_place_matrix_transpose] ERROR");
    $finish;
  end

  function automatic data_t any_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic bit pick_known(int unsigned span, output idx_t idx);
    idx_t probe;
    for (int n = 0; n < 200; n++) begin
      probe = idx_t'($urandom_range(0, span - 1));
      if (sb.shadow_known[probe]) begin
        idx = probe;
        return 1'b1;
      end
    end
    idx = '0;
    return 1'b0;
  endfunction

  task automatic put_item(op_t op, idx_t idx, data_t val);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.cell_index    <= idx;
    in_ch.element_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_item(op, idx, val);
    if (op != OP_UNUSED) items_sent++;
    calm = items_sent >= CALM_FROM;
  endtask

  // only write registers once the block has drained
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, dim_t data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.reg_data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.take_config(idx, data);
  endtask

  task automatic set_shape(dim_t rows, dim_t cols, bit poke_unused);
    settle();
    put_reg(REG_ROW_COUNT, rows);
    put_reg(REG_COLUMN_COUNT, cols);
    if (poke_unused) put_reg(REG_UNUSED, dim_t'($urandom()));
    cfg_ch.valid <= 1'b0;
    shapes++;
  endtask

  task automatic random_item(int unsigned span);
    int unsigned roll;
    idx_t        idx;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      if (pick_known(roll < 45 ? span : CELL_CAPACITY, idx)) begin
        put_item(OP_READ, idx, $urandom());
      end else begin
        put_item(OP_WRITE, idx_t'($urandom_range(0, span - 1)), any_value());
      end
    end else if (roll < 90) begin
      put_item(OP_WRITE, idx_t'($urandom_range(0, roll < 80 ? span - 1 : CELL_CAPACITY - 1)),
               any_value());
    end else begin
      put_item(OP_UNUSED, idx_t'($urandom()), $urandom());
    end
  endtask

  task automatic run_phase(int unsigned rows, int unsigned cols);
    int unsigned cells;
    int unsigned span;
    int unsigned p;
    bit          fits;
    set_shape(dim_t'(rows), dim_t'(cols), $urandom_range(0, 15) == 0);
    cells = rows * cols;
    fits  = cells != 0 && cells <= CELL_CAPACITY;
    span  = fits ? cells : CELL_CAPACITY;
    if (fits && span <= 256) begin
      for (p = 0; p < span; p++) put_item(OP_WRITE, idx_t'(p), any_value());
    end else begin
      repeat (fits ? 96 : 8) put_item(OP_WRITE, idx_t'($urandom_range(0, span - 1)), any_value());
    end
    repeat ($urandom_range(1, 3)) begin
      put_item(OP_RUN, idx_t'($urandom()), $urandom());
      repeat ($urandom_range(4, 14)) random_item(span);
    end
    if (span <= 256 && $urandom_range(0, 1) == 0) begin
      for (p = 0; p < span; p++) begin
        if (sb.shadow_known[p]) put_item(OP_READ, idx_t'(p), $urandom());
      end
    end
  endtask

  task automatic random_phase();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      case ($urandom_range(0, 5))
        0:       run_phase(64, 64);
        1:       run_phase(1, 64);
        2:       run_phase(64, 1);
        3:       run_phase(127, 1);
        4:       run_phase(1, 127);
        default: run_phase(100, 3);
      endcase
    end else if (sel < 12) begin
      case ($urandom_range(0, 3))
        0:       run_phase(0, $urandom_range(0, 127));
        1:       run_phase($urandom_range(1, 127), 0);
        2:       run_phase($urandom_range(65, 127), $urandom_range(65, 127));
        default: run_phase(127, 127);
      endcase
    end else if (sel < 30) begin
      run_phase($urandom_range(1, 16), $urandom_range(1, 16));
    end else begin
      run_phase($urandom_range(1, 7), $urandom_range(1, 7));
    end
  endtask

  initial begin : stimulus
    int unsigned p;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_WRITE;
    in_ch.cell_index    <= '0;
    in_ch.element_value <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.reg_index    <= REG_ROW_COUNT;
    cfg_ch.reg_data     <= dim_t'(1);
    rst_n               <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, unused code, 1x1 shape left by reset
    put_item(OP_WRITE, '0, '0);
    put_item(OP_READ, '0, '1);
    put_item(OP_WRITE, '1, '1);
    put_item(OP_READ, '1, '0);
    put_item(OP_WRITE, 12'hAAA, 32'hA5A5_5A5A);
    put_item(OP_WRITE, 12'h555, 32'h5A5A_A5A5);
    put_item(OP_UNUSED, 12'hAAA, '1);
    put_item(OP_READ, 12'hAAA, '0);
    put_item(OP_READ, 12'h555, '0);
    put_item(OP_RUN, '0, '0);
    put_item(OP_READ, '0, '0);

    // refused sizes: zero rows, over capacity
    set_shape(dim_t'(0), dim_t'(5), 1'b1);
    put_item(OP_RUN, '0, '0);
    set_shape(dim_t'(127), dim_t'(127), 1'b0);
    put_item(OP_RUN, '1, '1);
    set_shape(dim_t'(65), dim_t'(64), 1'b0);
    put_item(OP_RUN, '0, '0);

    set_shape(dim_t'(2), dim_t'(3), 1'b0);
    for (p = 0; p < 6; p++) put_item(OP_WRITE, idx_t'(p), data_t'(32'h100 + p));
    put_item(OP_RUN, '0, '0);
    for (p = 0; p < 6; p++) put_item(OP_READ, idx_t'(p), '0);

    while (items_sent < ITEM_TARGET) random_phase();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items over %0d matrix shapes: %0d reads, %0d transposes, %0d refused",
             items_sent, shapes, sb.read_count, sb.done_count, sb.refused_count);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("[in_place_matrix_transpose] OK");
    end else begin
      $display("[in_place_matrix_transpose] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ipmt_pkg.sv
hw/rtl/ipmt_if.sv
hw/rtl/in_place_matrix_transpose.sv
tb/sv/tb_in_place_matrix_transpose.sv
